@@ rtl/core/wsda_pkg.sv @@
// Shared types, widths, register codes and the vane table of the wind averager.
`default_nettype none

package wsda_pkg;

	// Averaging window in samples (1 to 64)
	localparam int WINDOW = 10;

	// Field widths
	localparam int TIME_W   = 32;
	localparam int VANE_W   = 12;
	localparam int DEB_W    = 10;
	localparam int FACTOR_W = 16;
	localparam int CLICK_W  = 16;
	localparam int SPEED_W  = 16;
	localparam int BEAR_W   = 9;
	localparam int AVGB_W   = 12;

	// Accumulator widths
	localparam int CNT_W    = 7;
	localparam int SSUM_W   = 22;
	localparam int UNWRAP_W = 14;
	localparam int BSUM_W   = 20;

	// Serial arithmetic widths
	localparam int MUL_W     = 16;
	localparam int PROD_W    = 2 * MUL_W;
	localparam int DIV_NUM_W = 42;
	localparam int DIV_DEN_W = 32;

	// Stream and configuration port widths
	localparam int IN_TDATA_W  = 48;
	localparam int OUT_USED_W  = 2 * SPEED_W + BEAR_W + SPEED_W + AVGB_W;
	localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;
	localparam int CFG_IDX_W   = 4;
	localparam int CFG_DATA_W  = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR = CFG_IDX_W'(1);

	// Register reset values
	localparam logic [DEB_W-1:0]    DEBOUNCE_RST = DEB_W'(10);
	localparam logic [FACTOR_W-1:0] FACTOR_RST   = FACTOR_W'(700);

	// Angles in degrees
	localparam int HALF_TURN = 180;
	localparam int FULL_TURN = 360;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SCALE,
		ST_DIV,
		ST_UPDATE,
		ST_AVG_SPD,
		ST_AVG_BRG,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic done;
		logic sat;
	} div_status_t;

	// Vane converter reading to bearing in degrees
	function automatic logic [BEAR_W-1:0] vane_to_bearing(input logic [VANE_W-1:0] adc);
		logic [BEAR_W-1:0] b;
		if (adc <= VANE_W'(1400))      b = BEAR_W'(0);
		else if (adc <= VANE_W'(1930)) b = BEAR_W'(270);
		else if (adc <= VANE_W'(2270)) b = BEAR_W'(315);
		else if (adc <= VANE_W'(2790)) b = BEAR_W'(0);
		else if (adc <= VANE_W'(3120)) b = BEAR_W'(225);
		else if (adc <= VANE_W'(3570)) b = BEAR_W'(45);
		else if (adc <= VANE_W'(3700)) b = BEAR_W'(180);
		else if (adc <= VANE_W'(3950)) b = BEAR_W'(135);
		else                           b = BEAR_W'(90);
		return b;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/wsda_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
`default_nettype none

module wsda_mul import wsda_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MUL_W-1:0]  a,
	input  wire logic [MUL_W-1:0]  b,
	output logic                   done,
	output logic [PROD_W-1:0]      prod
);

	localparam int CW = $clog2(MUL_W);
	localparam logic [CW-1:0] LAST = CW'(MUL_W - 1);

	logic [MUL_W-1:0]  a_q;
	logic [MUL_W-1:0]  b_q;
	logic [PROD_W-1:0] acc_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + CW'(1);
			busy_q <= (cnt_q != LAST);
			done_q <= (cnt_q == LAST);
		end else begin
			done_q <= 1'b0;
		end
	end

	// MSB first: double the partial product, add the multiplicand on a set bit
	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[PROD_W-2:0], 1'b0} + (b_q[MUL_W-1] ? PROD_W'(a_q) : '0);
			b_q   <= {b_q[MUL_W-2:0], 1'b0};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

`default_nettype wire

@@ rtl/core/wsda_div.sv @@
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none

module wsda_div import wsda_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic [DIV_NUM_W-1:0] dividend,
	input  wire logic [DIV_DEN_W-1:0] divisor,
	output div_status_t               status,
	output logic [DIV_NUM_W-1:0]      quotient
);

	localparam int CW = $clog2(DIV_NUM_W);
	localparam logic [CW-1:0] LAST = CW'(DIV_NUM_W - 1);

	logic [DIV_NUM_W-1:0] num_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIV_DEN_W:0] rem_sh;
	logic [DIV_DEN_W:0] rem_sub;
	logic               ge;

	// Bring in the next dividend bit and try the subtract
	always_comb begin
		rem_sh  = {rem_q, num_q[DIV_NUM_W-1]};
		rem_sub = rem_sh - {1'b0, den_q};
		ge      = (rem_sh >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q + CW'(1);
			busy_q <= (cnt_q != LAST);
			done_q <= (cnt_q == LAST);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
			rem_q <= ge ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
		end
	end

	// A zero divisor yields all ones, which also reads as saturated
	assign status.done = done_q;
	assign status.sat  = |quo_q[DIV_NUM_W-1:SPEED_W];
	assign quotient    = quo_q;

endmodule

`default_nettype wire

@@ rtl/core/wind_speed_direction_averager.sv @@
// Top level of the wind speed and direction averager.
// A click request is taken and gives no result. A sample passes the serial multiply and a
// serial divide to its result, and two more serial divides by the window length when it
// closes a window. Samples are taken one at a time, through the serial multiplier and the
// shared divider; clicks are taken only while no sample is in flight. Asynchronous reset
// (active low) clears control, configuration and window state, not per-sample or output data.
`default_nettype none

module wind_speed_direction_averager import wsda_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// Input stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] time_ms, [43:32] vane_reading
	input  wire logic                   s_tuser,  // [0] action: 0 click, 1 sample
	// Result stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata,  // [15:0] speed_mm_s, [24:16] bearing_deg,
	                                              // [40:25] gust_mm_s, [56:41] avg_speed_mm_s,
	                                              // [68:57] avg_bearing_deg
	output logic                        m_tlast,  // window_done
	// Configuration writes
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	localparam int DELTA_W = UNWRAP_W + 1;
	localparam int AVG_W   = BSUM_W + 1;
	localparam logic signed [DELTA_W-1:0]  HALF_P   = DELTA_W'(HALF_TURN);
	localparam logic signed [DELTA_W-1:0]  HALF_N   = -HALF_P;
	localparam logic signed [UNWRAP_W-1:0] FULL_U   = UNWRAP_W'(FULL_TURN);
	localparam logic signed [AVG_W-1:0]    FULL_A   = AVG_W'(FULL_TURN);
	localparam logic [CNT_W-1:0]           WIN_CNT  = CNT_W'(WINDOW);
	localparam logic [DIV_DEN_W-1:0]       WIN_DEN  = DIV_DEN_W'(WINDOW);

	state_t state_q, state_d;

	// Configuration registers
	logic [DEB_W-1:0]    debounce_q;
	logic [FACTOR_W-1:0] factor_q;

	// Architectural state
	logic [CLICK_W-1:0]         click_count_q;
	logic [TIME_W-1:0]          last_click_q;
	logic [TIME_W-1:0]          last_sample_q;
	logic [SPEED_W-1:0]         gust_q;
	logic [SSUM_W-1:0]          speed_sum_q;
	logic signed [UNWRAP_W-1:0] unwrap_q;
	logic signed [BSUM_W-1:0]   bsum_q;
	logic [CNT_W-1:0]           scount_q;
	logic [SPEED_W-1:0]         avg_speed_q;
	logic [AVGB_W-1:0]          avg_bearing_q;
	logic                       win_q;

	// Per-sample working registers
	logic [TIME_W-1:0]  elapsed_q;
	logic [BEAR_W-1:0]  bearing_q;
	logic [SPEED_W-1:0] speed_q;

	// Output register
	logic                   out_valid_q;
	logic                   out_last_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic [TIME_W-1:0] s_time;
	logic [VANE_W-1:0] s_vane;
	logic              in_acc;
	logic              click_ok;
	logic              out_free;

	// Arithmetic unit hookup
	logic                 mul_start;
	logic                 mul_done;
	logic [PROD_W-1:0]    mul_prod;
	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	div_status_t          div_st;
	logic [DIV_NUM_W-1:0] div_quo;

	logic [DIV_NUM_W-1:0] prod_ext;
	logic [DIV_NUM_W-1:0] scaled;

	// Sample update terms
	logic                       first;
	logic signed [UNWRAP_W-1:0] brg_u;
	logic signed [DELTA_W-1:0]  delta;
	logic signed [UNWRAP_W-1:0] corr;
	logic signed [UNWRAP_W-1:0] d_new;
	logic signed [BSUM_W-1:0]   bsum_new;
	logic [SSUM_W-1:0]          ssum_new;
	logic [CNT_W-1:0]           cnt_new;
	logic                       win_now;
	logic [SPEED_W-1:0]         gust_new;
	logic [BSUM_W-1:0]          bsum_mag;
	logic [BSUM_W-1:0]          avg_mag;
	logic signed [AVG_W-1:0]    avg_raw;
	logic signed [AVG_W-1:0]    avg_fix;

	assign s_time    = s_tdata[TIME_W-1:0];
	assign s_vane    = s_tdata[TIME_W +: VANE_W];
	assign s_tready  = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;

	// Clicks at or within the debounce time of the last accepted click are dropped
	assign click_ok = (s_time - last_click_q) > TIME_W'(debounce_q);

	// clicks * factor * 1000, with 1000 = 1024 - 32 + 8
	assign prod_ext = DIV_NUM_W'(mul_prod);
	assign scaled   = (prod_ext << 10) - (prod_ext << 5) + (prod_ext << 3);

	// Unwrap: the new unwrapped bearing is the vane bearing, moved by a full turn when
	// it jumps more than half a turn away from the last one
	always_comb begin
		first    = (scount_q == '0);
		brg_u    = $signed(UNWRAP_W'(bearing_q));
		delta    = $signed(DELTA_W'(bearing_q)) - $signed({unwrap_q[UNWRAP_W-1], unwrap_q});
		if (delta < HALF_N)      corr = FULL_U;
		else if (delta > HALF_P) corr = -FULL_U;
		else                     corr = '0;
		d_new    = first ? brg_u : brg_u + corr;
		bsum_new = first ? $signed(BSUM_W'(bearing_q))
		                 : bsum_q + $signed({{(BSUM_W-UNWRAP_W){d_new[UNWRAP_W-1]}}, d_new});
		ssum_new = speed_sum_q + SSUM_W'(speed_q);
		cnt_new  = scount_q + CNT_W'(1);
		win_now  = (cnt_new >= WIN_CNT);
		gust_new = (speed_q > gust_q) ? speed_q : gust_q;
	end

	// Bearing average: divide the magnitude, restore the sign (truncation toward zero),
	// then one full-turn correction
	always_comb begin
		bsum_mag = bsum_q[BSUM_W-1] ? BSUM_W'(-bsum_q) : BSUM_W'(bsum_q);
		avg_mag  = div_quo[BSUM_W-1:0];
		avg_raw  = bsum_q[BSUM_W-1] ? -$signed({1'b0, avg_mag}) : $signed({1'b0, avg_mag});
		if (avg_raw >= FULL_A)                 avg_fix = avg_raw - FULL_A;
		else if (avg_raw < $signed(AVG_W'(0))) avg_fix = avg_raw + FULL_A;
		else                                   avg_fix = avg_raw;
	end

	wsda_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (click_count_q),
		.b      (factor_q),
		.done   (mul_done),
		.prod   (mul_prod)
	);

	wsda_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_num),
		.divisor  (div_den),
		.status   (div_st),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer: the divider is shared by the speed, the average speed and the
	// average bearing
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && s_tuser) begin
					mul_start = 1'b1;
					state_d   = ST_MUL;
				end
			end
			ST_MUL: begin
				if (mul_done) state_d = ST_SCALE;
			end
			ST_SCALE: begin
				div_start = 1'b1;
				div_num   = scaled;
				div_den   = elapsed_q;
				state_d   = ST_DIV;
			end
			ST_DIV: begin
				if (div_st.done) state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				if (win_now) begin
					div_start = 1'b1;
					div_num   = DIV_NUM_W'(ssum_new);
					div_den   = WIN_DEN;
					state_d   = ST_AVG_SPD;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_AVG_SPD: begin
				if (div_st.done) begin
					div_start = 1'b1;
					div_num   = DIV_NUM_W'(bsum_mag);
					div_den   = WIN_DEN;
					state_d   = ST_AVG_BRG;
				end
			end
			ST_AVG_BRG: begin
				if (div_st.done) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration writes; unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			factor_q   <= FACTOR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_DEBOUNCE:     debounce_q <= cfg_data[DEB_W-1:0];
				REG_SPEED_FACTOR: factor_q   <= cfg_data[FACTOR_W-1:0];
				default:          ;
			endcase
		end
	end

	// Click counting and the sample time base
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			click_count_q <= '0;
			last_click_q  <= '0;
			last_sample_q <= '0;
		end else if (in_acc) begin
			if (s_tuser) begin
				// The multiplier takes the count at this edge; clear it for the next period
				click_count_q <= '0;
				last_sample_q <= s_time;
			end else if (click_ok) begin
				last_click_q <= s_time;
				if (click_count_q != '1) click_count_q <= click_count_q + CLICK_W'(1);
			end
		end
	end

	// Window accumulators and averages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gust_q        <= '0;
			speed_sum_q   <= '0;
			unwrap_q      <= '0;
			bsum_q        <= '0;
			scount_q      <= '0;
			avg_speed_q   <= '0;
			avg_bearing_q <= '0;
			win_q         <= 1'b0;
		end else begin
			case (state_q)
				ST_UPDATE: begin
					gust_q      <= gust_new;
					speed_sum_q <= ssum_new;
					unwrap_q    <= d_new;
					bsum_q      <= bsum_new;
					scount_q    <= cnt_new;
					win_q       <= 1'b0;
				end
				ST_AVG_SPD: begin
					if (div_st.done) avg_speed_q <= div_quo[SPEED_W-1:0];
				end
				ST_AVG_BRG: begin
					if (div_st.done) begin
						avg_bearing_q <= avg_fix[AVGB_W-1:0];
						speed_sum_q   <= '0;
						unwrap_q      <= '0;
						bsum_q        <= '0;
						scount_q      <= '0;
						win_q         <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// Per-sample payload: elapsed time and bearing at the request, speed after the divide
	always_ff @(posedge clk) begin
		if (in_acc && s_tuser) begin
			elapsed_q <= s_time - last_sample_q;
			bearing_q <= vane_to_bearing(s_vane);
		end
		if (state_q == ST_DIV && div_st.done) begin
			speed_q <= div_st.sat ? '1 : div_quo[SPEED_W-1:0];
		end
	end

	// Output register: hold a result until taken while the input side moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= {{OUT_PAD_W{1'b0}}, avg_bearing_q, avg_speed_q, gust_q,
			               bearing_q, speed_q};
			out_last_q <= win_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

	// The window count never rests at or above the window length
	a_count_below_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (scount_q < WIN_CNT))
		else $error("sample count reached the window length while idle");

	// The multiplier only finishes while the sequencer waits for it
	a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> (state_q == ST_MUL))
		else $error("multiplier finished outside its wait state");

	// A new result is only loaded from the output state
	a_load_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_OUT))
		else $error("result loaded outside the output state");

	// The reported gust is never below the reported speed
	a_gust_ge_speed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_data_q[2*SPEED_W+BEAR_W-1:SPEED_W+BEAR_W] >=
		                 out_data_q[SPEED_W-1:0]))
		else $error("gust below speed in a result");

	// No click is counted while a sample is in flight
	a_clicks_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> $stable(click_count_q))
		else $error("click count moved during sample processing");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the wind speed and direction averager.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import wsda_pkg::*;

	// Request kinds carried on s_tuser
	localparam logic ACT_CLICK  = 1'b0;
	localparam logic ACT_SAMPLE = 1'b1;

	// Register indexes the block does not decode; writes there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = CFG_IDX_W'(15);

	// Vane thresholds (upper bound of each band) and the bearing of each band, lowest first
	localparam logic [8*VANE_W-1:0] VANE_EDGES = {
		12'd3950, 12'd3700, 12'd3570, 12'd3120, 12'd2790, 12'd2270, 12'd1930, 12'd1400};
	localparam logic [9*BEAR_W-1:0] VANE_BEARINGS = {
		9'd90, 9'd135, 9'd180, 9'd45, 9'd225, 9'd0, 9'd315, 9'd270, 9'd0};

	// Let a window-closing sample finish before touching registers
	localparam int SETTLE_CYCLES = 300;
	localparam int CYCLE_LIMIT   = 3_000_000;

	typedef struct packed {
		logic               action;
		logic [TIME_W-1:0]  time_ms;
		logic [VANE_W-1:0]  vane;
	} wind_item_t;

	typedef struct packed {
		logic [SPEED_W-1:0]       speed;
		logic [BEAR_W-1:0]        bearing;
		logic [SPEED_W-1:0]       gust;
		logic [SPEED_W-1:0]       avg_speed;
		logic signed [AVGB_W-1:0] avg_bearing;
		logic                     done;
	} wind_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   s_tuser = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	wind_item_t   item_q[$];    // requests waiting to be driven
	wind_report_t report_q[$];  // reports the block still owes us

	// Mirror of the block's registers and state, advanced on each accepted request
	logic [DEB_W-1:0]    wx_debounce    = DEBOUNCE_RST;
	logic [FACTOR_W-1:0] wx_factor      = FACTOR_RST;
	logic [CLICK_W-1:0]  wx_clicks      = '0;
	logic [TIME_W-1:0]   wx_last_click  = '0;
	logic [TIME_W-1:0]   wx_last_sample = '0;
	logic [SPEED_W-1:0]  wx_gust        = '0;
	logic [SSUM_W-1:0]   wx_speed_sum   = '0;
	logic [UNWRAP_W-1:0] wx_unwrap      = '0;
	logic [BSUM_W-1:0]   wx_bearing_sum = '0;
	logic [CNT_W-1:0]    wx_count       = '0;
	logic [SPEED_W-1:0]  wx_avg_speed   = '0;
	logic [AVGB_W-1:0]   wx_avg_bearing = '0;

	// Stimulus bookkeeping
	logic [TIME_W-1:0] now_ms = '0;
	logic [TIME_W-1:0] last_sample_ms = '0;
	int stim_debounce = 10;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit in_taken = 1'b0;

	int errors = 0;
	int cycles = 0;
	int n_clicks = 0;
	int n_samples = 0;
	int n_reports = 0;
	int n_windows = 0;

	wind_speed_direction_averager uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Walk the threshold bands from the bottom until the reading no longer exceeds the edge
	function automatic logic [BEAR_W-1:0] bearing_of(input logic [VANE_W-1:0] reading);
		int band;
		band = 0;
		while (band < 8 && reading > VANE_EDGES[VANE_W*band +: VANE_W])
			band++;
		return VANE_BEARINGS[BEAR_W*band +: BEAR_W];
	endfunction

	// Advance the mirrored state by one request; returns 1 when a report is owed
	function automatic bit compute_report(input wind_item_t it, output wind_report_t rep);
		logic [TIME_W-1:0]    gap;
		logic [63:0]          quot;
		logic [SPEED_W-1:0]   spd;
		logic [BEAR_W-1:0]    brg;
		logic signed [13:0]   w14;
		logic signed [19:0]   w20;
		int d, delta, sum, avg;
		rep = '0;
		if (it.action == ACT_CLICK) begin
			gap = it.time_ms - wx_last_click;
			if (gap > TIME_W'(wx_debounce)) begin
				wx_last_click = it.time_ms;
				if (wx_clicks != '1)
					wx_clicks = wx_clicks + 1'b1;
			end
			return 1'b0;
		end

		// Speed over the elapsed time; zero time and oversize quotients saturate
		gap = it.time_ms - wx_last_sample;
		if (gap == '0) begin
			spd = '1;
		end else begin
			quot = 64'(wx_clicks) * 64'(wx_factor) * 64'd1000 / 64'(gap);
			spd = (quot > 64'hFFFF) ? '1 : quot[SPEED_W-1:0];
		end
		wx_clicks = '0;
		wx_last_sample = it.time_ms;
		wx_speed_sum = wx_speed_sum + SSUM_W'(spd);
		if (spd > wx_gust)
			wx_gust = spd;

		// Unwrap the bearing against the running value so averages cross north cleanly
		brg = bearing_of(it.vane);
		if (wx_count == '0) begin
			d = int'(brg);
			sum = d;
		end else begin
			w14 = wx_unwrap;
			d = w14;
			delta = int'(brg) - d;
			if (delta < -HALF_TURN)
				d += delta + FULL_TURN;
			else if (delta > HALF_TURN)
				d += delta - FULL_TURN;
			else
				d += delta;
			w14 = d[13:0];
			d = w14;
			w20 = wx_bearing_sum;
			sum = w20 + d;
			w20 = sum[19:0];
			sum = w20;
		end
		wx_unwrap = d[UNWRAP_W-1:0];
		wx_bearing_sum = sum[BSUM_W-1:0];
		wx_count = wx_count + 1'b1;

		if (wx_count >= WINDOW) begin
			avg = sum / WINDOW;
			if (avg >= FULL_TURN)
				avg -= FULL_TURN;
			else if (avg < 0)
				avg += FULL_TURN;
			wx_avg_bearing = avg[AVGB_W-1:0];
			wx_avg_speed = SPEED_W'(wx_speed_sum / WINDOW);
			wx_speed_sum = '0;
			wx_bearing_sum = '0;
			wx_unwrap = '0;
			wx_count = '0;
			rep.done = 1'b1;
		end

		rep.speed = spd;
		rep.bearing = brg;
		rep.gust = wx_gust;
		rep.avg_speed = wx_avg_speed;
		rep.avg_bearing = wx_avg_bearing;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// Monitor: check reports, predict from accepted requests, mirror register writes
	always @(posedge clk) begin : watch
		wind_report_t want;
		wind_item_t   seen;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (report_q.size() == 0) begin
					$error("report arrived with nothing outstanding");
					errors++;
				end else begin
					want = report_q.pop_front();
					n_reports++;
					if (want.done)
						n_windows++;
					check_field("speed_mm_s", want.speed, m_tdata[15:0]);
					check_field("bearing_deg", want.bearing, m_tdata[24:16]);
					check_field("gust_mm_s", want.gust, m_tdata[40:25]);
					check_field("avg_speed_mm_s", want.avg_speed, m_tdata[56:41]);
					check_field("avg_bearing_deg", int'(want.avg_bearing),
						int'($signed(m_tdata[68:57])));
					check_field("window_done", want.done, m_tlast);
				end
			end
			if (s_tvalid && s_tready) begin
				in_taken = 1'b1;
				seen.action = s_tuser;
				seen.time_ms = s_tdata[TIME_W-1:0];
				seen.vane = s_tdata[TIME_W +: VANE_W];
				if (seen.action == ACT_CLICK)
					n_clicks++;
				else
					n_samples++;
				if (compute_report(seen, want))
					report_q.push_back(want);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE:     wx_debounce = cfg_data[DEB_W-1:0];
					REG_SPEED_FACTOR: wx_factor = cfg_data[FACTOR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// Driver: hold a request until taken, then offer the next one unless idling
	always @(negedge clk) begin : feed
		wind_item_t nxt;
		if (!s_tvalid || in_taken) begin
			in_taken = 1'b0;
			if (arst_n && item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt = item_q.pop_front();
				s_tvalid <= 1'b1;
				s_tuser <= nxt.action;
				s_tdata <= IN_TDATA_W'({nxt.vane, nxt.time_ms});
			end else begin
				s_tvalid <= 1'b0;
			end
		end
		m_tready <= arst_n && ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	task automatic add_item(input logic action, input logic [TIME_W-1:0] t,
			input logic [VANE_W-1:0] reading);
		wind_item_t it;
		it.action = action;
		it.time_ms = t;
		it.vane = reading;
		item_q.push_back(it);
	endtask

	// Half the readings on either side of a band edge, the rest anywhere
	function automatic logic [VANE_W-1:0] pick_vane();
		if ($urandom_range(0, 1) == 0)
			return VANE_EDGES[VANE_W*$urandom_range(0, 7) +: VANE_W] + VANE_W'($urandom_range(0, 1));
		return VANE_W'($urandom_range(0, 4095));
	endfunction

	// Queue realistic weather: bursts of clicks around, within and past the debounce time, then a sample.
	// With rough set, also samples at zero or tiny elapsed time to force saturation.
	task automatic queue_weather(input int n, input bit rough);
		int made, burst, gap, pick;
		logic [TIME_W-1:0] t;
		made = 0;
		while (made < n) begin
			burst = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 30) : $urandom_range(0, 5);
			for (int i = 0; i < burst; i++) begin
				pick = $urandom_range(0, 3);
				if (pick == 0)
					gap = stim_debounce + $urandom_range(0, 2) - 1;
				else if (pick == 1)
					gap = $urandom_range(0, stim_debounce);
				else
					gap = stim_debounce + 1 + $urandom_range(0, 400);
				if (gap < 0)
					gap = 0;
				now_ms += TIME_W'(gap);
				add_item(ACT_CLICK, now_ms, pick_vane());
			end
			made += burst;
			pick = $urandom_range(0, 19);
			if (rough && pick == 0) begin
				t = last_sample_ms;
			end else if (rough && pick == 1) begin
				t = last_sample_ms + TIME_W'($urandom_range(1, 8));
			end else if (pick == 2) begin
				t = $urandom;
			end else if (pick == 3) begin
				// stray click anywhere in time
				add_item(ACT_CLICK, $urandom, VANE_W'($urandom));
				made++;
				t = now_ms + TIME_W'($urandom_range(1, 3000));
			end else begin
				t = now_ms + TIME_W'($urandom_range(1, 3000));
			end
			add_item(ACT_SAMPLE, t, pick_vane());
			now_ms = t;
			last_sample_ms = t;
			made++;
		end
	endtask

	// Wait until every request is taken and every report is in, then let the block settle
	task automatic quiesce();
		while (item_q.size() != 0 || s_tvalid || report_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [CFG_DATA_W-1:0] deb, input logic [CFG_DATA_W-1:0] factor);
		write_reg(REG_DEBOUNCE, deb);
		write_reg(REG_SPEED_FACTOR, factor);
		stim_debounce = int'(deb[DEB_W-1:0]);
	endtask

	initial begin : stimulus
		logic [TIME_W-1:0] t0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Sender seldom idles, receiver mostly stalls
		send_idle_pct = 9;
		recv_stall_pct = 67;

		// Directed, reset register values: debounce edge, every vane band edge, time wrap
		add_item(ACT_CLICK, 32'd5, 12'd0);        // within debounce of the reset click time
		add_item(ACT_CLICK, 32'd10, 12'hFFF);     // exactly at debounce: drop
		add_item(ACT_CLICK, 32'd11, 12'd0);       // one past: count
		add_item(ACT_CLICK, 32'd21, 12'd0);
		add_item(ACT_CLICK, 32'd22, 12'd0);
		add_item(ACT_SAMPLE, 32'd1000, 12'd0);
		for (int k = 0; k < 8; k++) begin
			add_item(ACT_SAMPLE, TIME_W'(1250 + 500 * k), VANE_EDGES[VANE_W*k +: VANE_W]);
			add_item(ACT_SAMPLE, TIME_W'(1500 + 500 * k),
				VANE_EDGES[VANE_W*k +: VANE_W] + 1'b1);
		end
		add_item(ACT_SAMPLE, 32'hFFFF_FF00, 12'hFFF);
		add_item(ACT_CLICK, 32'hFFFF_FFF8, 12'd0);
		add_item(ACT_CLICK, 32'h0000_0005, 12'd0);  // crosses the time wrap
		add_item(ACT_SAMPLE, 32'h0000_0100, 12'd2048);
		now_ms = 32'h100;
		last_sample_ms = 32'h100;
		quiesce();

		set_regs(16'd1000, 16'd350);
		queue_weather(365, 1'b0);
		quiesce();

		set_regs(16'd0, 16'd0);
		queue_weather(365, 1'b0);
		quiesce();

		// Now the other way round
		send_idle_pct = 67;
		recv_stall_pct = 9;

		// Upper register bits must be dropped; unused indexes ignored
		write_reg(REG_UNUSED_LO, 16'h0000);
		write_reg(REG_UNUSED_HI, 16'hFFFF);
		set_regs(16'hFFFF, 16'd2000);
		// zero elapsed time, first with no clicks, then with a click pending
		add_item(ACT_SAMPLE, now_ms + 32'd500, 12'd100);
		add_item(ACT_SAMPLE, now_ms + 32'd500, 12'd3000);
		add_item(ACT_CLICK, now_ms + 32'd5000, 12'd0);
		add_item(ACT_SAMPLE, now_ms + 32'd500, 12'd3600);
		now_ms = now_ms + 32'd5000;
		last_sample_ms = now_ms - 32'd4500;
		queue_weather(365, 1'b1);
		quiesce();

		set_regs(16'd25, 16'hFFFF);
		// quotient overflow, then a large numerator over the longest elapsed time
		t0 = now_ms;
		add_item(ACT_SAMPLE, t0 + 32'd1, 12'd0);
		add_item(ACT_CLICK, t0 + 32'd30, 12'd0);
		add_item(ACT_SAMPLE, t0 + 32'd40, 12'd0);
		for (int k = 1; k <= 30; k++)
			add_item(ACT_CLICK, t0 + 32'd40 + TIME_W'(26 * k), 12'd0);
		add_item(ACT_SAMPLE, t0 + 32'd39, 12'd4095);
		now_ms = t0 + 32'd39;
		last_sample_ms = now_ms;
		queue_weather(180, 1'b1);
		// hold the sender until the block has answered everything, then resume
		quiesce();
		queue_weather(180, 1'b1);
		quiesce();

		// No idling from here on
		send_idle_pct = 0;
		recv_stall_pct = 0;

		set_regs(16'd5, 16'd700);
		queue_weather(365, 1'b1);
		quiesce();

		// Factor 1 with a burst of back-to-back clicks over very long sample periods
		set_regs(16'd0, 16'd1);
		t0 = now_ms + 32'd1;
		add_item(ACT_SAMPLE, t0, 12'd0);
		for (int k = 1; k <= 40; k++)
			add_item(ACT_CLICK, t0 + TIME_W'(k), 12'd0);
		add_item(ACT_SAMPLE, t0 + 32'd1_000_000, 12'd0);
		add_item(ACT_SAMPLE, t0 + 32'd2_000_000, 12'd4000);
		quiesce();

		$display("summary: %0d clicks and %0d samples accepted, %0d reports checked, %0d windows",
			n_clicks, n_samples, n_reports, n_windows);
		$display("summary: seven register settings incl. debounce 0/1023 and factor 0/65535, %s",
			"wrapped time and saturated speed");
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/wsda_pkg.sv
rtl/core/wsda_mul.sv
rtl/core/wsda_div.sv
rtl/core/wind_speed_direction_averager.sv
test/testbench.sv
